FILE: rtl/core/fbsg_pkg.sv
// Shared types, codes and the control store of the FAT boot-sector geometry unit.
// No dependencies; used by fbsg_div and fat_boot_sector_geometry_unit.
package fbsg_pkg;

   localparam int STEP_W    = 4;
   localparam int DIV_W     = 32;
   localparam int DEN_W     = 16;
   localparam int DIV_CNT_W = 6;

   // result status codes
   localparam logic [1:0] STAT_USABLE = 2'd0;
   localparam logic [1:0] STAT_UNAV   = 2'd1;
   localparam logic [1:0] STAT_FAT32  = 2'd2;

   // request kinds
   localparam logic CMD_BUILD   = 1'b0;
   localparam logic CMD_RECHECK = 1'b1;

   // register indexes
   localparam logic [1:0] REG_MAX_SECTOR_BYTES  = 2'd0;
   localparam logic [1:0] REG_MAX_CLUSTER_COUNT = 2'd1;
   localparam logic [1:0] REG_FAT12_LIMIT       = 2'd2;
   localparam logic [1:0] REG_FAT16_CEILING     = 2'd3;

   typedef enum logic [3:0] {
      OP_CHKZ,      // flag: sector size or cluster size is zero
      OP_DIVR,      // start root directory division, store FAT area product
      OP_WAIT,      // hold until the divider is idle
      OP_GEOM,      // store basic geometry
      OP_DATA,      // store data start
      OP_DIVC,      // start cluster count division
      OP_CEIL,      // flag: cluster count above FAT16 ceiling, else store it
      OP_LIMIT,     // limit checks, FAT type, cluster byte product
      OP_SET_UNAV,
      OP_SET_F32,
      OP_EMIT       // load the result register and finish
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,    // advance by one
      COND_JUMP,    // go to target
      COND_FLAG,    // go to target when the datapath flag is set
      COND_END      // finish the transaction
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   localparam logic [STEP_W-1:0] STEP_BUILD   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RECHECK = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_UNAV    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_F32     = 4'd11;

   function automatic uword_type fbsg_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      case (step)
         4'd0:    w = '{OP_CHKZ,     COND_FLAG, STEP_UNAV};
         4'd1:    w = '{OP_DIVR,     COND_NEXT, '0};
         4'd2:    w = '{OP_WAIT,     COND_NEXT, '0};
         4'd3:    w = '{OP_GEOM,     COND_NEXT, '0};
         4'd4:    w = '{OP_DATA,     COND_NEXT, '0};
         4'd5:    w = '{OP_DIVC,     COND_NEXT, '0};
         4'd6:    w = '{OP_WAIT,     COND_NEXT, '0};
         4'd7:    w = '{OP_CEIL,     COND_FLAG, STEP_F32};
         4'd8:    w = '{OP_LIMIT,    COND_NEXT, '0};
         4'd9:    w = '{OP_EMIT,     COND_END,  '0};
         4'd10:   w = '{OP_SET_UNAV, COND_JUMP, STEP_EMIT};
         4'd11:   w = '{OP_SET_F32,  COND_JUMP, STEP_EMIT};
         default: w = '{OP_EMIT,     COND_END,  '0};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/fbsg_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on fbsg_pkg for widths.
module fbsg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fbsg_pkg::DIV_W-1:0] dividend,
   input  logic [fbsg_pkg::DEN_W-1:0] divisor,
   output logic                       busy,
   output logic [fbsg_pkg::DIV_W-1:0] quotient
);
   import fbsg_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       trial, diff;
   logic                 qbit;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      diff   = trial - {1'b0, den_ff};
      qbit   = ~diff[DEN_W];
      rem_in = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_W-2:0], qbit};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/fat_boot_sector_geometry_unit.sv
// Top level of the FAT12/FAT16 boot-sector geometry unit: microcoded sequencer,
// datapath, register file and result register. Depends on fbsg_pkg and fbsg_div.
//
// Channel   Direction  Handshake               Moves
// req_*     in         tvalid/tready           boot sector fields (tdata), command (tuser)
// rsp_*     out        tvalid/tready           geometry words (tdata), status+type (tuser)
// csr_*     in/out     APB psel/penable/pready four 16-bit limit registers
//
// A build transaction's length is set by the two serial divisions of a 32-bit
// dividend (root directory length, cluster count) sharing one divider; a recheck
// skips both. One transaction is in work at a time; the next is accepted
// while the previous result still waits in the result register. A stalled
// result holds the sequencer at its final step.
// Reset clears the control state, restores the limit registers and zeroes the
// kept geometry.
module fat_boot_sector_geometry_unit (
   input  logic         clock,
   input  logic         reset,
   // slave side
   input  logic         req_tvalid,
   output logic         req_tready,
   // spc[7:0] bps[23:8] root_entries[39:24] reserved[55:40] fat_copies[63:56]
   // sectors_per_fat[79:64] short_total[95:80] long_total[127:96]
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,   // cmd[0]
   // master side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sector_bytes[15:0] cluster_sectors[31:16] cluster_bytes[47:32]
   // root_dir_sectors[63:48] fat_sectors[79:64] second_fat_start[95:80]
   // data_start[111:96] cluster_total[127:112]
   output logic [127:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // status[1:0] is_fat16[2]
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import fbsg_pkg::*;

   // ---------------- configuration registers ----------------
   logic [15:0] max_sb_ff, max_cc_ff, fat12_lim_ff, fat16_ceil_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sb_ff     <= 16'd8192;
         max_cc_ff     <= 16'd32767;
         fat12_lim_ff  <= 16'd4078;
         fat16_ceil_ff <= 16'd65518;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MAX_SECTOR_BYTES:  max_sb_ff     <= csr_pwdata[15:0];
            REG_MAX_CLUSTER_COUNT: max_cc_ff     <= csr_pwdata[15:0];
            REG_FAT12_LIMIT:       fat12_lim_ff  <= csr_pwdata[15:0];
            REG_FAT16_CEILING:     fat16_ceil_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MAX_SECTOR_BYTES:  csr_prdata = {16'd0, max_sb_ff};
         REG_MAX_CLUSTER_COUNT: csr_prdata = {16'd0, max_cc_ff};
         REG_FAT12_LIMIT:       csr_prdata = {16'd0, fat12_lim_ff};
         REG_FAT16_CEILING:     csr_prdata = {16'd0, fat16_ceil_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------- latched request fields ----------------
   logic [7:0]  spc_ff, nfat_ff;
   logic [15:0] bps_ff, dir_ff, res_ff, spf_ff, ssec_ff;
   logic [31:0] lsec_ff;
   logic        req_acc;

   assign req_acc = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         spc_ff  <= req_tdata[7:0];
         bps_ff  <= req_tdata[23:8];
         dir_ff  <= req_tdata[39:24];
         res_ff  <= req_tdata[55:40];
         nfat_ff <= req_tdata[63:56];
         spf_ff  <= req_tdata[79:64];
         ssec_ff <= req_tdata[95:80];
         lsec_ff <= req_tdata[127:96];
      end
   end

   // ---------------- sequencer ----------------
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         uw;
   logic              flag;       // datapath condition for COND_FLAG
   logic              hold;       // stay on the current step

   assign uw         = fbsg_rom(step_ff);
   assign req_tready = ~busy_ff;

   // ---------------- datapath ----------------
   logic [15:0] h_sb_ff, h_cs_ff, h_rds_ff, h_fs_ff, h_sfs_ff, h_ds_ff, h_ct_ff;
   logic        h_f16_ff;
   logic [15:0] prod_ff;
   logic [1:0]  status_ff;

   logic        div_start, div_busy;
   logic [31:0] div_num, div_quo;
   logic [15:0] div_den;
   logic [15:0] res_eff;
   logic [31:0] sectors;
   logic        limit_fail;

   assign res_eff    = (res_ff == 16'd0) ? 16'd1 : res_ff;
   assign sectors    = (ssec_ff != 16'd0) ? {16'd0, ssec_ff} : lsec_ff;
   assign limit_fail = (h_sb_ff > max_sb_ff) || (h_ct_ff > max_cc_ff);

   always_comb begin
      div_start = 1'b0;
      div_num   = {11'd0, dir_ff, 5'd0};
      div_den   = bps_ff;
      flag      = 1'b0;
      hold      = 1'b0;
      unique case (uw.op)
         OP_CHKZ: flag = (spc_ff == 8'd0) || (bps_ff == 16'd0);
         OP_DIVR: div_start = busy_ff;
         OP_DIVC: begin
            div_start = busy_ff;
            div_num   = sectors - {16'd0, h_ds_ff};
            div_den   = {8'd0, spc_ff};
         end
         OP_WAIT: hold = div_busy;
         OP_CEIL: flag = div_quo > {16'd0, fat16_ceil_ff};
         OP_EMIT: hold = rsp_tvalid & ~rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (req_acc) begin
            busy_in = 1'b1;
            step_in = (req_tuser == CMD_RECHECK) ? STEP_RECHECK : STEP_BUILD;
         end
      end else if (!hold) begin
         unique case (uw.cond)
            COND_NEXT: step_in = step_ff + 1'b1;
            COND_JUMP: step_in = uw.target;
            COND_FLAG: step_in = flag ? uw.target : step_ff + 1'b1;
            COND_END:  busy_in = 1'b0;
            default:   busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   fbsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // kept geometry: reset zero, written by the build steps; a recheck also writes the FAT type flag
   always_ff @(posedge clock) begin
      if (reset) begin
         h_sb_ff  <= '0;
         h_cs_ff  <= '0;
         h_rds_ff <= '0;
         h_fs_ff  <= '0;
         h_sfs_ff <= '0;
         h_ds_ff  <= '0;
         h_ct_ff  <= '0;
         h_f16_ff <= 1'b0;
      end else if (busy_ff) begin
         case (uw.op)
            OP_GEOM: begin
               h_sb_ff  <= bps_ff;
               h_cs_ff  <= {8'd0, spc_ff};
               h_rds_ff <= div_quo[15:0];
               h_fs_ff  <= spf_ff;
               h_sfs_ff <= res_eff + spf_ff;
            end
            // reserved + FAT area + root directory, wrapping at 16 bits
            OP_DATA:  h_ds_ff <= res_eff + prod_ff + h_rds_ff;
            OP_CEIL: begin
               if (!flag) begin
                  h_ct_ff <= div_quo[15:0];
               end
            end
            OP_LIMIT: begin
               if (!limit_fail) begin
                  h_f16_ff <= h_ct_ff > fat12_lim_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // product register (low 16 bits only) and status of the transaction in work
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         case (uw.op)
            OP_DIVR:     prod_ff   <= {8'd0, nfat_ff} * spf_ff;
            OP_LIMIT: begin
               prod_ff   <= h_cs_ff * h_sb_ff;
               status_ff <= limit_fail ? STAT_UNAV : STAT_USABLE;
            end
            OP_SET_UNAV: status_ff <= STAT_UNAV;
            OP_SET_F32:  status_ff <= STAT_FAT32;
            default: ;
         endcase
      end
   end

   // ---------------- result register ----------------
   logic        rsp_valid_ff;
   logic [15:0] cbytes;
   logic        emit;

   assign emit = busy_ff & (uw.op == OP_EMIT) & ~hold;

   always_comb begin
      case (status_ff)
         STAT_USABLE: cbytes = prod_ff;
         STAT_FAT32:  cbytes = 16'hFFFF;
         default:     cbytes = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata <= {h_ct_ff, h_ds_ff, h_sfs_ff, h_fs_ff, h_rds_ff, cbytes,
                       h_cs_ff, h_sb_ff};
         rsp_tuser <= {h_f16_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("invalid status code on result");

   a_unav_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_UNAV |-> rsp_tdata[47:32] == 16'd0)
      else $error("unavailable drive reports nonzero cluster bytes");

   a_f32_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_FAT32 |-> rsp_tdata[47:32] == 16'hFFFF)
      else $error("FAT32 result without all-ones cluster bytes");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in work");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking bench for fat_boot_sector_geometry_unit: directed and random boot sector
// transactions, an in-bench geometry predictor and APB limit-register traffic.
// Depends on fbsg_pkg and the RTL of the unit only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbsg_pkg::*;

   // One boot sector transaction as it travels on req_*.
   typedef struct {
      logic        cmd;
      logic [7:0]  spc;
      logic [15:0] bps;
      logic [15:0] dir;
      logic [15:0] res;
      logic [7:0]  nfat;
      logic [15:0] spf;
      logic [15:0] ssec;
      logic [31:0] lsec;
   } geo_req_type;

   // One geometry transaction as it travels on rsp_*.
   typedef struct {
      logic [1:0]  status;
      logic [15:0] sector_bytes;
      logic [15:0] cluster_sectors;
      logic [15:0] cluster_bytes;
      logic [15:0] root_dir_sectors;
      logic [15:0] fat_sectors;
      logic [15:0] second_fat_start;
      logic [15:0] data_start;
      logic [15:0] cluster_total;
      logic        is_fat16;
   } geo_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // spc, bps, root_entries, reserved, fat_copies, sectors_per_fat, short_total, long_total
   logic [127:0] req_tdata = '0;
   logic         req_tuser = CMD_BUILD;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // sector_bytes, cluster_sectors, cluster_bytes, root_dir_sectors, fat_sectors,
   // second_fat_start, data_start, cluster_total
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;               // status, is_fat16
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   fat_boot_sector_geometry_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Transactions waiting to be driven, and geometry still owed by the unit.
   geo_req_type bpb_pending_q[$];
   geo_rsp_type geometry_due_q[$];
   geo_req_type req_in_flight;
   int          mismatches = 0;
   int          send_idle_pct = 6;
   int          recv_stall_pct = 60;

   // Mirror of the limit registers, at their reset values.
   logic [15:0] lim_max_sector     = 16'd8192;
   logic [15:0] lim_max_clusters   = 16'd32767;
   logic [15:0] lim_fat12          = 16'd4078;
   logic [15:0] lim_fat16_ceiling  = 16'd65518;

   // Geometry the unit keeps between transactions; cleared by reset.
   logic [15:0] kept_sector_bytes     = '0;
   logic [15:0] kept_cluster_sectors  = '0;
   logic [15:0] kept_root_dir         = '0;
   logic [15:0] kept_fat_sectors      = '0;
   logic [15:0] kept_second_fat       = '0;
   logic [15:0] kept_data_start       = '0;
   logic [15:0] kept_cluster_total    = '0;
   logic        kept_fat16            = 1'b0;

   // Root directory length: 32-byte entries over the sector size, truncated, then cut
   // to 16 bits. Only called with a non-zero sector size.
   function automatic logic [15:0] root_dir_len(input logic [15:0] dir, input logic [15:0] bps);
      logic [31:0] quot;
      quot = ({16'd0, dir} << 5) / {16'd0, bps};
      return quot[15:0];
   endfunction

   // First data sector, all terms wrapping at 16 bits; a zero reserved count counts as one.
   function automatic logic [15:0] data_area_start(input geo_req_type r);
      logic [15:0] rsv;
      logic [15:0] sum;
      rsv = (r.res == 16'd0) ? 16'd1 : r.res;
      sum = rsv + {8'd0, r.nfat} * r.spf + root_dir_len(r.dir, r.bps);
      return sum;
   endfunction

   // Advance the kept geometry by one transaction and return the result it owes.
   function automatic geo_rsp_type predict_geometry(input geo_req_type r);
      geo_rsp_type g;
      logic [31:0] sectors;
      logic [31:0] clusters;
      logic [15:0] rsv;
      logic [15:0] cbytes;
      logic [1:0]  status;
      logic        settled;
      settled = 1'b0;
      status  = STAT_USABLE;
      cbytes  = '0;
      if (r.cmd == CMD_BUILD) begin
         if (r.spc == 8'd0 || r.bps == 16'd0) begin
            // nothing stored on a zero sector or cluster size
            status  = STAT_UNAV;
            settled = 1'b1;
         end else begin
            rsv                  = (r.res == 16'd0) ? 16'd1 : r.res;
            kept_sector_bytes    = r.bps;
            kept_cluster_sectors = {8'd0, r.spc};
            kept_root_dir        = root_dir_len(r.dir, r.bps);
            kept_fat_sectors     = r.spf;
            kept_second_fat      = rsv + r.spf;
            kept_data_start      = data_area_start(r);
            sectors  = (r.ssec != 16'd0) ? {16'd0, r.ssec} : r.lsec;
            clusters = (sectors - {16'd0, kept_data_start}) / {24'd0, r.spc};
            if (clusters > {16'd0, lim_fat16_ceiling}) begin
               // FAT32: count and type flag stay as they were
               status  = STAT_FAT32;
               cbytes  = '1;
               settled = 1'b1;
            end else begin
               kept_cluster_total = clusters[15:0];
            end
         end
      end
      if (!settled) begin
         if (kept_sector_bytes > lim_max_sector || kept_cluster_total > lim_max_clusters) begin
            status = STAT_UNAV;
         end else begin
            kept_fat16 = (kept_cluster_total > lim_fat12);
            cbytes     = kept_cluster_sectors * kept_sector_bytes;
         end
      end
      g.status           = status;
      g.sector_bytes     = kept_sector_bytes;
      g.cluster_sectors  = kept_cluster_sectors;
      g.cluster_bytes    = cbytes;
      g.root_dir_sectors = kept_root_dir;
      g.fat_sectors      = kept_fat_sectors;
      g.second_fat_start = kept_second_fat;
      g.data_start       = kept_data_start;
      g.cluster_total    = kept_cluster_total;
      g.is_fat16         = kept_fat16;
      return g;
   endfunction

   function automatic geo_req_type make_build(input logic [7:0] spc, input logic [15:0] bps,
                                              input logic [15:0] dir, input logic [15:0] res,
                                              input logic [7:0] nfat, input logic [15:0] spf,
                                              input logic [15:0] ssec, input logic [31:0] lsec);
      geo_req_type r;
      r.cmd  = CMD_BUILD;
      r.spc  = spc;
      r.bps  = bps;
      r.dir  = dir;
      r.res  = res;
      r.nfat = nfat;
      r.spf  = spf;
      r.ssec = ssec;
      r.lsec = lsec;
      return r;
   endfunction

   // Mostly plausible boot sectors whose cluster count lands near one of the current
   // limits or at a random value; the rest are rechecks and raw noise.
   function automatic geo_req_type random_boot_sector();
      geo_req_type r;
      int          kind;
      int          anchor;
      int          delta;
      int          target;
      logic [31:0] sectors;
      kind   = $urandom_range(0, 99);
      r.spc  = 8'($urandom);
      r.bps  = 16'($urandom);
      r.dir  = 16'($urandom);
      r.res  = 16'($urandom);
      r.nfat = 8'($urandom);
      r.spf  = 16'($urandom);
      r.ssec = 16'($urandom);
      r.lsec = $urandom;
      if (kind < 12) begin
         r.cmd = CMD_RECHECK;
      end else if (kind < 25) begin
         r.cmd = CMD_BUILD;
         if ($urandom_range(0, 3) == 0) r.spc = '0;
         if ($urandom_range(0, 3) == 0) r.bps = '0;
      end else begin
         r.cmd  = CMD_BUILD;
         r.spc  = 8'd1 << $urandom_range(0, 7);
         if ($urandom_range(0, 9) == 0) r.spc = 8'($urandom_range(1, 255));
         r.bps  = 16'd128 << $urandom_range(0, 8);
         if ($urandom_range(0, 9) == 0) r.bps = 16'($urandom_range(1, 65535));
         r.dir  = 16'($urandom_range(0, 1023));
         r.res  = 16'($urandom_range(0, 40));
         r.nfat = 8'($urandom_range(1, 2));
         r.spf  = 16'($urandom_range(1, 300));
         case ($urandom_range(0, 4))
            0:       anchor = int'(lim_fat12);
            1:       anchor = int'(lim_max_clusters);
            2:       anchor = int'(lim_fat16_ceiling);
            default: anchor = $urandom_range(0, 70000);
         endcase
         delta  = $urandom_range(0, 4);
         target = anchor + delta - 2;
         if (target < 0) target = 0;
         sectors = 32'(data_area_start(r)) + 32'(target) * 32'(r.spc)
                   + 32'($urandom_range(0, r.spc - 1));
         if (sectors < 32'd65536 && sectors != 32'd0 && $urandom_range(0, 1) == 1) begin
            r.ssec = sectors[15:0];
         end else begin
            r.ssec = '0;
            r.lsec = sectors;
         end
      end
      return r;
   endfunction

   task automatic check_word(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0h, got %0h", field, want, got);
      end
   endtask

   // Driver: hold a transaction until taken, predict it at the accepting edge,
   // then load the next one unless the sender idles this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            geometry_due_q.push_back(predict_geometry(req_in_flight));
         end
         if (!req_tvalid || req_tready) begin
            if (bpb_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_in_flight = bpb_pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_in_flight.cmd;
               req_tdata  <= {req_in_flight.lsec, req_in_flight.ssec, req_in_flight.spf,
                              req_in_flight.nfat, req_in_flight.res, req_in_flight.dir,
                              req_in_flight.bps, req_in_flight.spc};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest owed geometry, field by field.
   always @(posedge clock) begin
      geo_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (geometry_due_q.size() == 0) begin
               mismatches++;
               $error("result transaction with no geometry owed");
            end else begin
               want = geometry_due_q.pop_front();
               check_word("status",           16'(want.status),   16'(rsp_tuser[1:0]));
               check_word("is_fat16",         16'(want.is_fat16), 16'(rsp_tuser[2]));
               check_word("sector_bytes",     want.sector_bytes,     rsp_tdata[15:0]);
               check_word("cluster_sectors",  want.cluster_sectors,  rsp_tdata[31:16]);
               check_word("cluster_bytes",    want.cluster_bytes,    rsp_tdata[47:32]);
               check_word("root_dir_sectors", want.root_dir_sectors, rsp_tdata[63:48]);
               check_word("fat_sectors",      want.fat_sectors,      rsp_tdata[79:64]);
               check_word("second_fat_start", want.second_fat_start, rsp_tdata[95:80]);
               check_word("data_start",       want.data_start,       rsp_tdata[111:96]);
               check_word("cluster_total",    want.cluster_total,    rsp_tdata[127:112]);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Hold until every queued transaction is taken and all geometry has come back,
   // then leave the unit a few quiet cycles.
   task automatic drain();
      while (bpb_pending_q.size() != 0 || req_tvalid || geometry_due_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write with random upper data bits, then read it back; update the mirror
   // only once the write edge has passed.
   task automatic write_limit(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MAX_SECTOR_BYTES:  lim_max_sector    = val;
         REG_MAX_CLUSTER_COUNT: lim_max_clusters  = val;
         REG_FAT12_LIMIT:       lim_fat12         = val;
         REG_FAT16_CEILING:     lim_fat16_ceiling = val;
         default: ;
      endcase
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_word("csr_prdata", val, csr_prdata[15:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_limits(input logic [15:0] sec, input logic [15:0] clus,
                               input logic [15:0] f12, input logic [15:0] f16);
      write_limit(REG_MAX_SECTOR_BYTES,  sec);
      write_limit(REG_MAX_CLUSTER_COUNT, clus);
      write_limit(REG_FAT12_LIMIT,       f12);
      write_limit(REG_FAT16_CEILING,     f16);
      @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) bpb_pending_q.push_back(random_boot_sector());
   endtask

   initial begin
      geo_req_type chk;
      chk      = make_build('0, '0, '0, '0, '0, '0, '0, '0);
      chk.cmd  = CMD_RECHECK;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender idles rarely, receiver stalls often. Directed cases at reset limits.
      send_idle_pct  = 6;
      recv_stall_pct = 60;
      bpb_pending_q.push_back(chk);                                           // recheck after reset
      bpb_pending_q.push_back(make_build(0, 512, 224, 1, 2, 9, 2880, 0));     // zero cluster size
      bpb_pending_q.push_back(make_build(1, 0, 224, 1, 2, 9, 2880, 0));       // zero sector size
      bpb_pending_q.push_back(chk);                                           // recheck after failure
      bpb_pending_q.push_back(make_build(1, 512, 224, 1, 2, 9, 2880, 0));     // floppy, FAT12
      bpb_pending_q.push_back(make_build(4, 512, 512, 1, 2, 64, 0, 100000));  // FAT16 via long total
      bpb_pending_q.push_back(make_build(2, 512, 512, 0, 2, 32, 20000, 0));   // reserved zero
      bpb_pending_q.push_back(make_build(1, 512, 512, 4, 2, 200, 100, 0));    // total below data start
      bpb_pending_q.push_back(chk);                                           // recheck after FAT32
      bpb_pending_q.push_back(make_build(2, 16384, 512, 1, 2, 16, 40000, 0)); // sector too large
      bpb_pending_q.push_back(make_build(1, 512, 512, 1, 2, 256, 0, 60000));  // too many clusters
      bpb_pending_q.push_back(make_build(128, 512, 512, 1, 2, 16, 0, 1000000)); // 64 KiB cluster
      bpb_pending_q.push_back(make_build('1, '1, '1, '1, '1, '1, '1, '1));    // every field all ones
      bpb_pending_q.push_back(make_build(1, 1, 65535, 1, 1, 1, 0, '1));       // root length wraps
      bpb_pending_q.push_back(make_build(0, 0, 0, 0, 0, 0, 0, 0));            // every field zero
      bpb_pending_q.push_back(make_build(8, 512, 512, 1, 2, 64, 0, 0));       // both totals zero
      bpb_pending_q.push_back(make_build(1, 512, 0, 1, 1, 1, 65520, 0));      // count at ceiling
      bpb_pending_q.push_back(make_build(1, 512, 0, 1, 1, 1, 65521, 0));      // one above ceiling
      bpb_pending_q.push_back(make_build(1, 512, 0, 1, 1, 1, 4080, 0));       // FAT12 limit
      bpb_pending_q.push_back(make_build(1, 512, 0, 1, 1, 1, 4081, 0));       // one above, FAT16
      bpb_pending_q.push_back(make_build(3, 2048, 16, 6, 3, 7, 9999, 0));     // odd cluster size
      bpb_pending_q.push_back(chk);
      drain();
      queue_random(130);
      drain();

      // Lowest limits: every build and recheck that reaches the limit checks should fail them.
      write_limits('0, '0, '0, '0);
      queue_random(100);
      drain();

      // Swap the idling: sender sparse, receiver eager. Highest limits first.
      send_idle_pct  = 60;
      recv_stall_pct = 6;
      write_limits('1, '1, '1, '1);
      queue_random(150);
      drain();
      write_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(150);
      drain();

      // No idling on either side; reset limits written back explicitly.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_limits(16'd8192, 16'd32767, 16'd4078, 16'd65518);
      queue_random(150);
      drain();
      write_limits(16'(16'd512 << $urandom_range(0, 6)), 16'($urandom),
                   16'($urandom_range(0, 8000)), 16'($urandom_range(30000, 65535)));
      queue_random(130);
      drain();

      repeat (100) @(posedge clock);
      if (geometry_due_q.size() != 0) begin
         mismatches++;
         $error("%0d geometry transactions never arrived", geometry_due_q.size());
      end
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #8ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
